// ----- rtl/mtp_pkg.sv -----
`default_nettype none

package mtp_pkg;

  localparam int unsigned SepCount   = 5;
  localparam int unsigned FieldCount = 6;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned MacW       = FieldCount * ByteW;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] HexTen    = 8'd10;

  localparam logic [2:0] ColonMax  = 3'(SepCount);

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  typedef struct packed {
    logic [MacW-1:0] mac_address;
    logic            format_error;
  } result_t;

  function automatic hex_digit_t decode_hex(input logic [7:0] ch);
    hex_digit_t d;
    logic [7:0] v;
    d = '0;
    v = '0;
    if (ch inside {[CharZero:CharNine]}) begin
      v = ch - CharZero;
      d.valid = 1'b1;
    end else if (ch inside {[CharLowA:CharLowF]}) begin
      v = ch - CharLowA + HexTen;
      d.valid = 1'b1;
    end else if (ch inside {[CharUpA:CharUpF]}) begin
      v = ch - CharUpA + HexTen;
      d.valid = 1'b1;
    end
    d.value = v[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mtp_if.sv -----
`default_nettype none

interface mtp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface mtp_result_if;
  logic                      valid;
  logic                      ready;
  logic [mtp_pkg::MacW-1:0]  mac_address;
  logic                      format_error;

  modport source (output valid, output mac_address, output format_error, input ready);
  modport sink   (input valid, input mac_address, input format_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/mac_address_text_parser_core.sv -----
// Parses a colon-separated hex MAC address ("aa:BB:0c:..") one character per
// cycle; a NUL character closes the string and yields one registered result,
// either the six bytes (first field in bits 47:40) or zero with
// format_error set. A field keeps its last two hex digits; an empty field is
// zero; any stray character or a sixth colon marks the string bad until the
// NUL. Throughput is one character per cycle: the parse state updates in the
// same cycle a character is taken, and results go through a result register
// backed by a one-entry skid buffer, so input stalls only when two results
// are waiting downstream.
`default_nettype none

module mac_address_text_parser_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  mtp_char_if.sink             in_i,
  mtp_result_if.source         out_o
);

  logic [7:0] fin_bytes_q [mtp_pkg::SepCount];
  logic [7:0] field_q, field_d;
  logic [2:0] colons_q, colons_d;
  logic       bad_q, bad_d;

  mtp_pkg::result_t out_q, skid_q, res_d;
  logic             out_valid_q, skid_valid_q;

  logic             in_fire, out_fire, is_nul, fin_we;
  mtp_pkg::hex_digit_t digit;

  assign in_i.ready  = ~skid_valid_q;
  assign in_fire     = in_i.valid & ~skid_valid_q;
  assign out_fire    = out_valid_q & out_o.ready;
  assign is_nul      = (in_i.character == mtp_pkg::CharNul);
  assign digit       = mtp_pkg::decode_hex(in_i.character);

  always_comb begin
    field_d = field_q;
    colons_d = colons_q;
    bad_d = bad_q;
    fin_we = 1'b0;
    res_d.mac_address = '0;
    res_d.format_error = 1'b1;
    if (!bad_q && colons_q == mtp_pkg::ColonMax) begin
      res_d.mac_address = {fin_bytes_q[0], fin_bytes_q[1], fin_bytes_q[2],
                           fin_bytes_q[3], fin_bytes_q[4], field_q};
      res_d.format_error = 1'b0;
    end
    if (in_fire) begin
      if (is_nul) begin
        field_d = '0;
        colons_d = '0;
        bad_d = 1'b0;
      end else if (!bad_q) begin
        if (in_i.character == mtp_pkg::CharColon) begin
          if (colons_q < mtp_pkg::ColonMax) begin
            fin_we = 1'b1;
            colons_d = colons_q + 3'd1;
            field_d = '0;
          end else begin
            bad_d = 1'b1;
          end
        end else if (digit.valid) begin
          field_d = {field_q[3:0], digit.value};
        end else begin
          bad_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= '0;
      colons_q <= '0;
      bad_q <= 1'b0;
    end else begin
      field_q <= field_d;
      colons_q <= colons_d;
      bad_q <= bad_d;
    end
  end

  // Finished fields: cleared on reset and after every NUL.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mtp_pkg::SepCount; i++) fin_bytes_q[i] <= '0;
    end else if (in_fire && is_nul) begin
      for (int i = 0; i < mtp_pkg::SepCount; i++) fin_bytes_q[i] <= '0;
    end else if (fin_we) begin
      fin_bytes_q[colons_q] <= field_q;
    end
  end

  // Result register plus skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && is_nul) begin
      if (out_valid_q && !out_o.ready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && is_nul) begin
      if (out_valid_q && !out_o.ready) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.mac_address  = out_q.mac_address;
  assign out_o.format_error = out_q.format_error;

endmodule

`default_nettype wire

// ----- rtl/mtp_checker.sv -----
`default_nettype none

module mtp_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     in_valid_i,
  input wire                     in_ready_i,
  input wire [7:0]               in_character_i,
  input wire                     out_valid_i,
  input wire                     out_ready_i,
  input wire [mtp_pkg::MacW-1:0] out_mac_address_i,
  input wire                     out_format_error_i
);

  logic in_fire, nul_fire;
  assign in_fire  = in_valid_i & in_ready_i;
  assign nul_fire = in_fire & (in_character_i == mtp_pkg::CharNul);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_mac_address_i) && $stable(out_format_error_i))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_format_error_i |-> out_mac_address_i == '0)
    else $error("error result carries a nonzero address");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !nul_fire |=> !out_valid_i)
    else $error("result appeared without a NUL transaction");

  a_nul_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && nul_fire |=> out_valid_i)
    else $error("NUL transaction gave no result");

endmodule

bind mac_address_text_parser_core mtp_checker u_mtp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_character_i     (in_i.character),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_mac_address_i  (out_o.mac_address),
  .out_format_error_i (out_o.format_error)
);

`default_nettype wire

// ----- sim/mtp_checker.sv -----
`default_nettype none

module mtp_scoreboard (
  input  wire         clk_i,
  input  wire         rst_ni,
  mtp_char_if         char_mon,
  mtp_result_if       res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned strings_o,
  output int unsigned flagged_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mtp_pkg::*;

  localparam int unsigned ReportLimit = 10;

  logic [ByteW-1:0] closed_fields [SepCount] = '{default: '0};
  logic [ByteW-1:0] open_field  = '0;
  logic [2:0]       colons_seen = '0;
  logic             text_bad    = 1'b0;

  result_t     parsed_q [$];
  int unsigned mismatches   = 0;
  int unsigned seen_results = 0;
  int unsigned seen_flagged = 0;

  task automatic clear_parse();
    foreach (closed_fields[k]) closed_fields[k] = '0;
    open_field  = '0;
    colons_seen = '0;
    text_bad    = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] ch);
    result_t    r;
    logic [3:0] nib;
    logic       is_hex;
    if (ch == CharNul) begin
      r.mac_address  = '0;
      r.format_error = 1'b1;
      if (!text_bad && colons_seen == ColonMax) begin
        for (int k = 0; k < SepCount; k++) begin
          r.mac_address = {r.mac_address[MacW-ByteW-1:0], closed_fields[k]};
        end
        r.mac_address  = {r.mac_address[MacW-ByteW-1:0], open_field};
        r.format_error = 1'b0;
      end
      parsed_q.push_back(r);
      clear_parse();
    end else if (!text_bad) begin
      if (ch == CharColon) begin
        // a sixth colon poisons the text, the count holds at five
        if (colons_seen < ColonMax) begin
          closed_fields[colons_seen] = open_field;
          colons_seen = colons_seen + 3'd1;
          open_field  = '0;
        end else begin
          text_bad = 1'b1;
        end
      end else begin
        is_hex = 1'b1;
        nib    = ch[3:0];
        if (ch >= CharZero && ch <= CharNine) begin
          nib = ch[3:0];
        end else if ((ch >= CharLowA && ch <= CharLowF) ||
                     (ch >= CharUpA && ch <= CharUpF)) begin
          nib = ch[3:0] + 4'd9;
        end else begin
          is_hex = 1'b0;
        end
        // keep only the last two digits of the field
        if (is_hex) open_field = {open_field[3:0], nib};
        else text_bad = 1'b1;
      end
    end
  endtask

  task automatic check_result(input logic [MacW-1:0] mac, input logic err);
    result_t want;
    seen_results++;
    if (err) seen_flagged++;
    if (parsed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("[%0t] unexpected result: mac %012h format_error %0b",
                 $realtime, mac, err);
      end
    end else begin
      want = parsed_q.pop_front();
      if (want.mac_address !== mac || want.format_error !== err) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display({"[%0t] result %0d: expected mac %012h format_error %0b, ",
                    "got mac %012h format_error %0b"},
                   $realtime, seen_results, want.mac_address, want.format_error,
                   mac, err);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      parsed_q.delete();
    end else begin
      // a result can never belong to a NUL taken at the same edge, so check first
      if (res_mon.valid && res_mon.ready) check_result(res_mon.mac_address, res_mon.format_error);
      if (char_mon.valid && char_mon.ready) parse_char(char_mon.character);
    end
    fail_count_o <= mismatches;
    pending_o    <= parsed_q.size();
    strings_o    <= seen_results;
    flagged_o    <= seen_flagged;
  end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtp_pkg::*;

  localparam int unsigned CharTarget  = 1650;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mtp_char_if   chr ();
  mtp_result_if res ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned strings_done;
  int unsigned strings_flagged;

  int unsigned chars_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          send_burst  = 1'b0;
  bit          sink_burst  = 1'b0;
  bit          paused      = 1'b0;
  logic [7:0]  text_q [$];

  always #5ns clk_i = ~clk_i;

  mac_address_text_parser_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (chr),
    .out_o  (res)
  );

  mtp_scoreboard u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_mon     (chr),
    .res_mon      (res),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .strings_o    (strings_done),
    .flagged_o    (strings_flagged)
  );

  function automatic int unsigned pick_gap(input bit burst);
    int unsigned roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return CharZero + 8'(v);
    return (upper ? CharUpA : CharLowA) + 8'(v - 4'd10);
  endfunction

  task automatic queue_text(input string s);
    foreach (s[i]) text_q.push_back(s[i]);
  endtask

  task automatic build_random_string();
    int unsigned kind;
    int unsigned fields;
    int unsigned digits;
    int unsigned start;
    int unsigned len;
    start = text_q.size();
    kind  = $urandom_range(0, 99);
    if (kind < 85) begin
      // mostly six fields, some with the wrong field count
      fields = (kind < 70) ? 6 : $urandom_range(1, 8);
      for (int f = 0; f < fields; f++) begin
        if (f > 0) text_q.push_back(CharColon);
        digits = ($urandom_range(0, 3) != 0) ? 2 : $urandom_range(0, 5);
        repeat (digits) begin
          text_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
      end
      // corrupt one character now and then
      if (text_q.size() > start && $urandom_range(0, 9) == 0) begin
        text_q[$urandom_range(start, text_q.size() - 1)] = 8'($urandom_range(1, 255));
      end
    end else begin
      len = $urandom_range(0, 12);
      repeat (len) begin
        case ($urandom_range(0, 2))
          0:       text_q.push_back(CharColon);
          1:       text_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                             1'($urandom_range(0, 1))));
          default: text_q.push_back(8'($urandom_range(1, 255)));
        endcase
      end
    end
    text_q.push_back(CharNul);
  endtask

  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      chr.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    chr.valid     <= 1'b1;
    chr.character <= c;
    do @(posedge clk_i); while (!chr.ready);
    chars_sent++;
  endtask

  task automatic send_all();
    while (text_q.size() > 0) send_char(text_q.pop_front());
  endtask

  initial begin
    chr.valid     = 1'b0;
    chr.character = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty string
    text_q.push_back(CharNul);
    // long first field, empty fields, both letter cases
    queue_text("1af:F9:::CA:0");
    text_q.push_back(CharNul);
    // sixth colon, then a stray byte after the error
    queue_text("::::::");
    text_q.push_back(8'hFF);
    text_q.push_back(CharNul);
    send_all();

    while (chars_sent < CharTarget) begin
      if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
      if ($urandom_range(0, 15) == 0) sink_burst = ~sink_burst;
      // hold off the sender once until the result side is drained
      if (!paused && chars_sent >= CharTarget / 2) begin
        paused = 1'b1;
        chr.valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      build_random_string();
      send_all();
    end

    chr.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d characters forming %0d strings, %0d of them flagged malformed.",
             chars_sent, strings_done, strings_flagged);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    res.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap(sink_burst);
      end
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((chr.valid && chr.ready) || (res.valid && res.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", IdleLimit);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/mtp_pkg.sv
rtl/mtp_if.sv
rtl/mac_address_text_parser_core.sv
rtl/mtp_checker.sv
sim/mtp_checker.sv
sim/tb.sv
